/* design/pnghcv_pkg.sv */
`default_nettype none

package pnghcv_pkg;

  typedef enum logic [2:0] {
    StOk          = 3'd0,
    StNotPng      = 3'd1,
    StMalformed   = 3'd2,
    StUnsupported = 3'd3,
    StBadFormat   = 3'd4,
    StInterlace   = 3'd5
  } status_e;

  localparam logic [31:0] TypeIhdr = 32'h4948_4452;
  localparam logic [31:0] TypeIdat = 32'h4944_4154;
  localparam logic [31:0] TypePlte = 32'h504C_5445;
  localparam logic [31:0] TypeIend = 32'h4945_4E44;

  localparam logic [5:0] SigLen         = 6'd8;
  localparam logic [5:0] TypeEndPos     = 6'd15;
  localparam logic [5:0] WidthEndPos    = 6'd19;
  localparam logic [5:0] HeightEndPos   = 6'd23;
  localparam logic [5:0] DepthPos       = 6'd24;
  localparam logic [5:0] ColourPos      = 6'd25;
  localparam logic [5:0] LastHeaderByte = 6'd28;
  localparam logic [5:0] HeaderEnd      = 6'd33;

  localparam logic [3:0] LenPhaseLast  = 4'd3;
  localparam logic [3:0] LenPhases     = 4'd4;
  localparam logic [3:0] TypePhaseLast = 4'd7;
  localparam logic [3:0] TypePhases    = 4'd8;

  localparam logic [31:0] CrcBytes     = 32'd4;
  localparam logic [15:0] MaxDimReset  = 16'd10000;
  localparam logic [4:0]  NoFormat     = 5'd16;

  localparam logic [7:0] ColourLum   = 8'd0;
  localparam logic [7:0] ColourRgb   = 8'd2;
  localparam logic [7:0] ColourIndex = 8'd3;
  localparam logic [7:0] ColourLuma  = 8'd4;
  localparam logic [7:0] ColourRgba  = 8'd6;

  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'd137;
      3'd1: b = 8'd80;
      3'd2: b = 8'd78;
      3'd3: b = 8'd71;
      3'd4: b = 8'd13;
      3'd5: b = 8'd10;
      3'd6: b = 8'd26;
      3'd7: b = 8'd10;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  // 1,2,4,8 map to 0..3, anything else to 4
  function automatic logic [2:0] depth_rank(input logic [7:0] depth);
    logic [2:0] r;
    case (depth)
      8'd1: r = 3'd0;
      8'd2: r = 3'd1;
      8'd4: r = 3'd2;
      8'd8: r = 3'd3;
      default: r = 3'd4;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] format_of(input logic [7:0] colour, input logic [7:0] depth);
    logic [2:0] r;
    logic [4:0] f;
    r = depth_rank(depth);
    case (colour)
      ColourLum:   f = r[2] ? NoFormat : {3'd0, r[1:0]};
      ColourRgb:   f = (depth == 8'd8) ? 5'd4 : ((depth == 8'd16) ? 5'd5 : NoFormat);
      ColourIndex: f = r[2] ? NoFormat : 5'd12 + {3'd0, r[1:0]};
      ColourLuma:  f = r[2] ? NoFormat : 5'd6 + {3'd0, r[1:0]};
      ColourRgba:  f = (depth == 8'd8) ? 5'd10 : ((depth == 8'd16) ? 5'd11 : NoFormat);
      default:     f = NoFormat;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

/* design/png_header_chunk_validator.sv */
`default_nettype none

// PNG header and chunk validator. Feed the bytes of one file in order, one per
// transfer, with end_of_file_i set on the last byte; exactly one result comes
// out per file: on the first error, at the end of the IEND frame, or on the
// last byte. Bytes after the result are dropped until the last byte, which
// always starts a new file. One byte is taken every cycle; a byte is
// registered, then a single per-byte update of the header and chunk counters
// runs and loads the result register. The input side stalls only when a result
// is due while the previous one has not been taken. The user must write
// max_dimension through cfg_we_i/cfg_wdata_i only while no file is in flight;
// the block itself does not enforce this.
module png_header_chunk_validator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  file_byte_i,
  input  wire logic        end_of_file_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [15:0]      image_width_o,
  output logic [15:0]      image_height_o,
  output logic [7:0]       bit_depth_o,
  output logic [7:0]       colour_kind_o,
  output logic [3:0]       format_code_o,
  output logic [31:0]      idat_total_o,
  output logic [30:0]      palette_length_o,
  output logic             saw_end_chunk_o
);
  import pnghcv_pkg::*;

  logic [15:0] max_dim_q;

  // input register
  logic       s1_valid_q;
  logic [7:0] byte_q;
  logic       eof_q;
  logic       s1_adv;

  // per-file state
  logic [5:0]  hdr_pos_q, hdr_pos_d;
  logic        sig_good_q, sig_good_d;
  logic [31:0] shift_q, shift_d;
  logic        ihdr_good_q, ihdr_good_d;
  logic [31:0] width_q, width_d;
  logic [31:0] height_q, height_d;
  logic [7:0]  depth_q, depth_d;
  logic [7:0]  colour_q, colour_d;
  logic [3:0]  phase_q, phase_d;
  logic [31:0] len_q, len_d;
  logic [31:0] kind_q, kind_d;
  logic [31:0] left_q, left_d;
  logic [31:0] idat_q, idat_d;
  logic [30:0] pal_q, pal_d;
  logic        given_q, given_d;

  logic        emit;
  status_e     emit_status;
  logic        end_seen;
  logic [31:0] left_dec;
  logic [32:0] idat_add;
  logic [4:0]  fmt;

  // result register
  logic        out_valid_q;
  status_e     out_status_q;
  logic [15:0] out_width_q;
  logic [15:0] out_height_q;
  logic [7:0]  out_depth_q;
  logic [7:0]  out_colour_q;
  logic [3:0]  out_format_q;
  logic [31:0] out_idat_q;
  logic [30:0] out_pal_q;
  logic        out_end_q;

  assign left_dec = (left_q == 32'd0) ? 32'd0 : left_q - 32'd1;
  assign idat_add = {1'b0, idat_q} + {1'b0, len_q};
  assign fmt      = format_of(colour_d, depth_d);

  always_comb begin
    hdr_pos_d   = hdr_pos_q;
    sig_good_d  = sig_good_q;
    shift_d     = shift_q;
    ihdr_good_d = ihdr_good_q;
    width_d     = width_q;
    height_d    = height_q;
    depth_d     = depth_q;
    colour_d    = colour_q;
    phase_d     = phase_q;
    len_d       = len_q;
    kind_d      = kind_q;
    left_d      = left_q;
    idat_d      = idat_q;
    pal_d       = pal_q;
    given_d     = given_q;
    emit        = 1'b0;
    emit_status = StOk;
    end_seen    = 1'b0;
    if (!given_q) begin
      if (hdr_pos_q < HeaderEnd) begin
        shift_d = {shift_q[23:0], byte_q};
        if (hdr_pos_q < SigLen && byte_q != magic_byte(hdr_pos_q[2:0])) begin
          sig_good_d = 1'b0;
        end
        if (hdr_pos_q == WidthEndPos) width_d = shift_d;
        if (hdr_pos_q == HeightEndPos) height_d = shift_d;
        if (hdr_pos_q == DepthPos) depth_d = byte_q;
        if (hdr_pos_q == ColourPos) colour_d = byte_q;
        if (hdr_pos_q == TypeEndPos && shift_d != TypeIhdr) ihdr_good_d = 1'b0;
        hdr_pos_d = hdr_pos_q + 6'd1;
        if (hdr_pos_q == LastHeaderByte) begin
          emit = 1'b1;
          if (!sig_good_d) begin
            emit_status = StNotPng;
          end else if (!ihdr_good_d) begin
            emit_status = StMalformed;
          end else if (width_d > {16'd0, max_dim_q} || height_d > {16'd0, max_dim_q}) begin
            emit_status = StBadFormat;
          end else if (fmt == NoFormat) begin
            emit_status = StBadFormat;
          end else if (shift_d[23:16] != 8'd0 || shift_d[15:8] != 8'd0) begin
            emit_status = StMalformed;
          end else if (shift_d[7:0] != 8'd0) begin
            emit_status = StInterlace;
          end else begin
            emit = 1'b0;
          end
        end
        if (!emit && eof_q) begin
          emit        = 1'b1;
          emit_status = (hdr_pos_q < LastHeaderByte) ? StNotPng : StOk;
        end
      end else begin
        if (phase_q < LenPhases) begin
          len_d   = {len_q[23:0], byte_q};
          phase_d = phase_q + 4'd1;
          if (phase_q == LenPhaseLast && len_d[31]) begin
            emit        = 1'b1;
            emit_status = StMalformed;
          end
        end else if (phase_q < TypePhases) begin
          kind_d  = {kind_q[23:0], byte_q};
          phase_d = phase_q + 4'd1;
          if (phase_q == TypePhaseLast) left_d = len_q + CrcBytes;
        end else begin
          left_d = left_dec;
          if (left_dec == 32'd0) begin
            if (kind_q == TypeIdat) begin
              idat_d = idat_add[32] ? '1 : idat_add[31:0];
            end else if (kind_q == TypePlte) begin
              pal_d = len_q[30:0];
            end else if (kind_q == TypeIend) begin
              emit        = 1'b1;
              emit_status = StOk;
              end_seen    = 1'b1;
            end else if (!kind_q[29]) begin
              emit        = 1'b1;
              emit_status = StUnsupported;
            end
            if (!emit) begin
              phase_d = 4'd0;
              len_d   = 32'd0;
              kind_d  = 32'd0;
            end
          end
        end
        if (!emit && eof_q) begin
          emit        = 1'b1;
          emit_status = (phase_d != 4'd0) ? StMalformed : StOk;
        end
      end
      if (emit) given_d = 1'b1;
    end
  end

  assign s1_adv     = s1_valid_q && (!emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dim_q <= MaxDimReset;
    end else if (cfg_we_i) begin
      max_dim_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= file_byte_i;
      eof_q  <= end_of_file_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_pos_q   <= '0;
      sig_good_q  <= 1'b1;
      shift_q     <= '0;
      ihdr_good_q <= 1'b1;
      width_q     <= '0;
      height_q    <= '0;
      depth_q     <= '0;
      colour_q    <= '0;
      phase_q     <= '0;
      len_q       <= '0;
      kind_q      <= '0;
      left_q      <= '0;
      idat_q      <= '0;
      pal_q       <= '0;
      given_q     <= 1'b0;
    end else if (s1_adv) begin
      if (eof_q) begin
        hdr_pos_q   <= '0;
        sig_good_q  <= 1'b1;
        shift_q     <= '0;
        ihdr_good_q <= 1'b1;
        width_q     <= '0;
        height_q    <= '0;
        depth_q     <= '0;
        colour_q    <= '0;
        phase_q     <= '0;
        len_q       <= '0;
        kind_q      <= '0;
        left_q      <= '0;
        idat_q      <= '0;
        pal_q       <= '0;
        given_q     <= 1'b0;
      end else begin
        hdr_pos_q   <= hdr_pos_d;
        sig_good_q  <= sig_good_d;
        shift_q     <= shift_d;
        ihdr_good_q <= ihdr_good_d;
        width_q     <= width_d;
        height_q    <= height_d;
        depth_q     <= depth_d;
        colour_q    <= colour_d;
        phase_q     <= phase_d;
        len_q       <= len_d;
        kind_q      <= kind_d;
        left_q      <= left_d;
        idat_q      <= idat_d;
        pal_q       <= pal_d;
        given_q     <= given_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // fields other than status read zero on an error
  always_ff @(posedge clk_i) begin
    if (s1_adv && emit) begin
      out_status_q <= emit_status;
      if (emit_status == StOk) begin
        out_width_q  <= width_d[15:0];
        out_height_q <= height_d[15:0];
        out_depth_q  <= depth_d;
        out_colour_q <= colour_d;
        out_format_q <= fmt[3:0];
        out_idat_q   <= idat_d;
        out_pal_q    <= pal_d;
        out_end_q    <= end_seen;
      end else begin
        out_width_q  <= '0;
        out_height_q <= '0;
        out_depth_q  <= '0;
        out_colour_q <= '0;
        out_format_q <= '0;
        out_idat_q   <= '0;
        out_pal_q    <= '0;
        out_end_q    <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign image_width_o    = out_width_q;
  assign image_height_o   = out_height_q;
  assign bit_depth_o      = out_depth_q;
  assign colour_kind_o    = out_colour_q;
  assign format_code_o    = out_format_q;
  assign idat_total_o     = out_idat_q;
  assign palette_length_o = out_pal_q;
  assign saw_end_chunk_o  = out_end_q;

endmodule

`default_nettype wire

/* design/pnghcv_checker.sv */
`default_nettype none

module pnghcv_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cfg_we_i,
  input wire logic [15:0] cfg_wdata_i,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [7:0]  file_byte_i,
  input wire logic        end_of_file_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [2:0]  status_o,
  input wire logic [15:0] image_width_o,
  input wire logic [15:0] image_height_o,
  input wire logic [7:0]  bit_depth_o,
  input wire logic [7:0]  colour_kind_o,
  input wire logic [3:0]  format_code_o,
  input wire logic [31:0] idat_total_o,
  input wire logic [30:0] palette_length_o,
  input wire logic        saw_end_chunk_o
);
  import pnghcv_pkg::*;

  logic unused_in;
  assign unused_in = cfg_we_i ^ (^cfg_wdata_i) ^ (^file_byte_i) ^ end_of_file_i;

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(idat_total_o))
    else $error("result changed while stalled");

  // a result always comes from an earlier byte transfer through the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StOk |-> image_width_o == 16'd0 && image_height_o == 16'd0
      && bit_depth_o == 8'd0 && colour_kind_o == 8'd0 && format_code_o == 4'd0
      && idat_total_o == 32'd0 && palette_length_o == 31'd0 && !saw_end_chunk_o)
    else $error("error result carries data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saw_end_chunk_o |-> status_o == StOk)
    else $error("IEND seen on a failed file");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StOk && colour_kind_o == ColourRgb
      |-> format_code_o == 4'd4 || format_code_o == 4'd5)
    else $error("rgb format code mismatch");

endmodule

bind png_header_chunk_validator pnghcv_checker u_pnghcv_checker (.*);

`default_nettype wire
